>>> hdl/pen_touch_packet_event_decoder_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the pen and touch packet decoder
// Shared property forms used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef PEN_TOUCH_PACKET_EVENT_DECODER_TOP_DEFINES_SVH
`define PEN_TOUCH_PACKET_EVENT_DECODER_TOP_DEFINES_SVH

// same-cycle implication
`define PTPE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ptpe_pkg.sv
// ---------------------------------------------------------------------------
// Pen and touch packet decoder package
// Event codes, packet lengths and the event record type.
// ---------------------------------------------------------------------------
package ptpe_pkg;

  localparam int unsigned MaxEvents = 6;
  localparam int unsigned BodyDepth = 8;

  typedef logic [2:0] ev_kind_t;
  typedef logic [1:0] ev_src_t;
  typedef logic [1:0] ev_btn_t;
  typedef logic [2:0] ev_count_t;
  typedef logic [3:0] byte_count_t;

  localparam ev_kind_t KIND_PRESS    = 3'd0;
  localparam ev_kind_t KIND_RELEASE  = 3'd1;
  localparam ev_kind_t KIND_MOVE     = 3'd2;
  localparam ev_kind_t KIND_PROX_IN  = 3'd3;
  localparam ev_kind_t KIND_PROX_OUT = 3'd4;

  localparam ev_src_t SRC_TOUCH  = 2'd0;
  localparam ev_src_t SRC_TIP    = 2'd1;
  localparam ev_src_t SRC_ERASER = 2'd2;

  localparam ev_btn_t BTN_NONE  = 2'd0;
  localparam ev_btn_t BTN_TIP   = 2'd1;
  localparam ev_btn_t BTN_LOWER = 2'd2;
  localparam ev_btn_t BTN_UPPER = 2'd3;

  localparam byte_count_t LEN_CONTROL = 4'd11;
  localparam byte_count_t LEN_TOUCH   = 4'd5;
  localparam byte_count_t LEN_PEN     = 4'd9;

  typedef struct packed {
    ev_kind_t kind;
    ev_src_t  src;
    ev_btn_t  btn;
  } ev_rec_t;

endpackage

>>> hdl/pen_touch_packet_event_decoder_top.sv
// ---------------------------------------------------------------------------
// Pen and touch tablet packet event decoder
// Frames serial tablet bytes into packets and emits pen and finger events.
//
//   channel | ports                         | direction
//   in      | in_valid, in_stall, in_rx_byte | byte transaction into block
//   out     | out_valid, out_stall, out_*    | event transaction out of block
//
// One byte is taken per cycle while in_stall is low; a byte reaches the framer
// in the cycle after it is accepted, and its events go through the event buffer
// and the output register to the out ports.
// A packet with k events holds the event buffer until all k are emitted, one
// event per cycle while out_stall does not hold the output; a packet-ending byte
// waits in the input register until the buffer is free.
// rst_n is synchronous: framing, pen and finger state and both valids clear.
// out_stall holds the output register; in_stall rises only when a packet
// ends while earlier events are still draining.
// ---------------------------------------------------------------------------
`include "pen_touch_packet_event_decoder_top_defines.svh"

module pen_touch_packet_event_decoder_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ptpe_pkg::ev_kind_t   out_event_kind,
  output ptpe_pkg::ev_src_t    out_event_source,
  output ptpe_pkg::ev_btn_t    out_button_number,
  output logic [13:0]          out_pos_x,
  output logic [13:0]          out_pos_y,
  output logic [9:0]           out_pen_pressure,
  output logic                 out_last_of_run
);
  import ptpe_pkg::*;

  // input register
  logic [7:0]  byte_r;
  logic        byte_vld_r;

  // framing state
  logic [6:0]  header_r;
  logic [6:0]  body_r [BodyDepth];
  byte_count_t cnt_r;
  logic        in_pkt_r;

  // tracked tool state
  logic pen_near_r, eraser_r, tip_r, lower_r, upper_r, finger_r;
  logic pen_near_nxt, eraser_nxt, tip_nxt, lower_nxt, upper_nxt, finger_nxt;

  // event buffer
  ev_rec_t    ev_list_r [MaxEvents];
  ev_count_t  ev_cnt_r;
  ev_count_t  ev_idx_r;
  logic [13:0] ev_x_r, ev_y_r;
  logic [9:0]  ev_pr_r;
  logic        ev_busy;

  // output register
  logic        out_valid_r;
  ev_rec_t     out_rec_r;
  logic [13:0] out_x_r, out_y_r;
  logic [9:0]  out_pr_r;
  logic        out_last_r;

  // framing combinational
  logic        is_start, body_wr, s1_done, s1_go, emit;
  logic        is_touch, is_pen;
  byte_count_t cnt_nxt, pkt_len;
  logic [2:0]  wr_idx;
  logic [6:0]  body_v [BodyDepth];
  logic [13:0] x_nxt, y_nxt;
  logic [9:0]  pr_nxt;
  ev_rec_t     list_nxt [MaxEvents];
  ev_count_t   n_nxt;

  assign ev_busy = (ev_idx_r != ev_cnt_r);

  always_comb begin
    is_start = byte_r[7];
    cnt_nxt  = cnt_r + 4'd1;
    wr_idx   = 3'(cnt_r - 4'd1);
    body_wr  = byte_vld_r && !is_start && in_pkt_r && (cnt_r >= 4'd1) && (cnt_r <= 4'd8);
    if (header_r[6]) begin
      pkt_len = LEN_CONTROL;
    end else if (header_r[4]) begin
      pkt_len = LEN_TOUCH;
    end else begin
      pkt_len = LEN_PEN;
    end
    is_touch = (pkt_len == LEN_TOUCH);
    is_pen   = (pkt_len == LEN_PEN);
    s1_done  = byte_vld_r && !is_start && in_pkt_r && (cnt_nxt >= pkt_len) && !header_r[6];
    s1_go    = byte_vld_r && !(s1_done && ev_busy);
    for (int i = 0; i < BodyDepth; i++) begin
      body_v[i] = (body_wr && (wr_idx == 3'(i))) ? byte_r[6:0] : body_r[i];
    end
  end

  assign in_stall = byte_vld_r && !s1_go;

  // packet decode and event list
  always_comb begin
    logic tip, b1, b2, prox;
    ev_src_t src;
    tip  = header_r[0];
    b1   = header_r[1];
    b2   = header_r[2];
    prox = header_r[5];
    src  = SRC_TIP;
    pen_near_nxt = pen_near_r;
    eraser_nxt   = eraser_r;
    tip_nxt      = tip_r;
    lower_nxt    = lower_r;
    upper_nxt    = upper_r;
    finger_nxt   = finger_r;
    n_nxt        = '0;
    for (int i = 0; i < MaxEvents; i++) begin
      list_nxt[i] = '{kind: KIND_MOVE, src: SRC_TOUCH, btn: BTN_NONE};
    end
    if (is_touch) begin
      x_nxt  = {body_v[0], body_v[1]};
      y_nxt  = {body_v[2], body_v[3]};
      pr_nxt = '0;
    end else begin
      x_nxt  = {body_v[0], body_v[1][6:2], body_v[5][6:5]};
      y_nxt  = {body_v[2], body_v[3][6:2], body_v[5][4:3]};
      pr_nxt = {body_v[5][2:0], body_v[4]};
    end

    if (is_touch && !pen_near_r) begin
      list_nxt[0] = '{kind: KIND_MOVE, src: SRC_TOUCH, btn: BTN_TIP};
      if (!tip && finger_r) begin
        finger_nxt = 1'b0;
        list_nxt[0].kind = KIND_RELEASE;
      end else if (tip && !finger_r) begin
        finger_nxt = 1'b1;
        list_nxt[0].kind = KIND_PRESS;
      end
      n_nxt = 3'd1;
    end else if (is_pen) begin
      if (prox && !pen_near_r) begin
        pen_near_nxt = 1'b1;
        eraser_nxt   = !tip && b2;
        list_nxt[n_nxt] = '{kind: KIND_PROX_IN, src: (eraser_nxt ? SRC_ERASER : SRC_TIP),
                            btn: BTN_NONE};
        n_nxt = n_nxt + 3'd1;
      end else if (!prox && pen_near_r) begin
        pen_near_nxt = 1'b0;
        list_nxt[n_nxt] = '{kind: KIND_PROX_OUT, src: (eraser_r ? SRC_ERASER : SRC_TIP),
                            btn: BTN_NONE};
        n_nxt = n_nxt + 3'd1;
      end else if (eraser_r && !b2) begin
        list_nxt[0] = '{kind: KIND_PROX_OUT, src: SRC_ERASER, btn: BTN_NONE};
        list_nxt[1] = '{kind: KIND_PROX_IN,  src: SRC_TIP,    btn: BTN_NONE};
        n_nxt      = 3'd2;
        eraser_nxt = 1'b0;
      end else if (!eraser_r && !tip && b2) begin
        list_nxt[0] = '{kind: KIND_PROX_OUT, src: SRC_TIP,    btn: BTN_NONE};
        list_nxt[1] = '{kind: KIND_PROX_IN,  src: SRC_ERASER, btn: BTN_NONE};
        n_nxt      = 3'd2;
        eraser_nxt = 1'b1;
      end

      src = eraser_nxt ? SRC_ERASER : SRC_TIP;
      if (tip != tip_r) begin
        tip_nxt = tip;
        list_nxt[n_nxt] = '{kind: (tip ? KIND_PRESS : KIND_RELEASE), src: src, btn: BTN_TIP};
        n_nxt = n_nxt + 3'd1;
      end
      if (!eraser_nxt) begin
        if (b1 != lower_r) begin
          lower_nxt = b1;
          list_nxt[n_nxt] = '{kind: (b1 ? KIND_PRESS : KIND_RELEASE), src: SRC_TIP,
                              btn: BTN_LOWER};
          n_nxt = n_nxt + 3'd1;
        end
        if (b2 != upper_r) begin
          upper_nxt = b2;
          list_nxt[n_nxt] = '{kind: (b2 ? KIND_PRESS : KIND_RELEASE), src: SRC_TIP,
                              btn: BTN_UPPER};
          n_nxt = n_nxt + 3'd1;
        end
      end
      list_nxt[n_nxt] = '{kind: KIND_MOVE, src: src, btn: BTN_NONE};
      n_nxt = n_nxt + 3'd1;
    end
  end

  assign emit = ev_busy && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r  <= 1'b0;
      header_r    <= '0;
      cnt_r       <= '0;
      in_pkt_r    <= 1'b0;
      pen_near_r  <= 1'b0;
      eraser_r    <= 1'b0;
      tip_r       <= 1'b0;
      lower_r     <= 1'b0;
      upper_r     <= 1'b0;
      finger_r    <= 1'b0;
      ev_cnt_r    <= '0;
      ev_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        byte_r     <= in_rx_byte;
        byte_vld_r <= 1'b1;
      end else if (s1_go) begin
        byte_vld_r <= 1'b0;
      end

      if (s1_go) begin
        if (is_start) begin
          header_r <= byte_r[6:0];
          cnt_r    <= 4'd1;
          in_pkt_r <= 1'b1;
        end else if (in_pkt_r) begin
          if (body_wr) begin
            body_r[wr_idx] <= byte_r[6:0];
          end
          if (cnt_nxt >= pkt_len) begin
            cnt_r    <= '0;
            in_pkt_r <= 1'b0;
          end else begin
            cnt_r <= cnt_nxt;
          end
        end
      end

      if (s1_go && s1_done) begin
        pen_near_r <= pen_near_nxt;
        eraser_r   <= eraser_nxt;
        tip_r      <= tip_nxt;
        lower_r    <= lower_nxt;
        upper_r    <= upper_nxt;
        finger_r   <= finger_nxt;
        ev_list_r  <= list_nxt;
        ev_cnt_r   <= n_nxt;
        ev_idx_r   <= '0;
        ev_x_r     <= x_nxt;
        ev_y_r     <= y_nxt;
        ev_pr_r    <= pr_nxt;
      end else if (emit) begin
        ev_idx_r <= ev_idx_r + 3'd1;
      end

      if (emit) begin
        out_valid_r <= 1'b1;
        out_rec_r   <= ev_list_r[ev_idx_r];
        out_x_r     <= ev_x_r;
        out_y_r     <= ev_y_r;
        out_pr_r    <= ev_pr_r;
        out_last_r  <= ((ev_idx_r + 3'd1) == ev_cnt_r);
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_kind    = out_rec_r.kind;
  assign out_event_source  = out_rec_r.src;
  assign out_button_number = out_rec_r.btn;
  assign out_pos_x         = out_x_r;
  assign out_pos_y         = out_y_r;
  assign out_pen_pressure  = out_pr_r;
  assign out_last_of_run   = out_last_r;

  `PTPE_ASSERT_NOW(a_idx_in_range, 1'b1, (ev_idx_r <= ev_cnt_r) && (ev_cnt_r <= 3'(MaxEvents)), "event index beyond event count")
  `PTPE_ASSERT_NOW(a_load_when_free, s1_go && s1_done, !ev_busy, "event list reloaded while events pending")
  `PTPE_ASSERT_NOW(a_hunt_count_zero, !in_pkt_r, cnt_r == '0, "byte count set while hunting for start")
  `PTPE_ASSERT_NEXT(a_last_drains, emit && ((ev_idx_r + 3'd1) == ev_cnt_r), !ev_busy, "event buffer not empty after last event")

endmodule

>>> tb/pen_touch_packet_event_decoder_top_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pen and touch packet event decoder testbench
// Streams tablet bytes into the decoder: a short directed opening, then
// mostly well-formed pen, touch and control packets with random content,
// mixed with stray and truncated traffic. A predictor tracks framing and the
// pen and finger state, and every event transaction is compared in order.
// Sender gaps and receiver stalls vary by phase, including a long hold-off.
// ---------------------------------------------------------------------------
module pen_touch_packet_event_decoder_top_test;
  import ptpe_pkg::*;

  typedef struct packed {
    ev_kind_t    kind;
    ev_src_t     src;
    ev_btn_t     btn;
    logic [13:0] x;
    logic [13:0] y;
    logic [9:0]  pressure;
    logic        last;
  } tablet_event_t;

  localparam int HoldCycles = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  ev_kind_t    out_event_kind;
  ev_src_t     out_event_source;
  ev_btn_t     out_button_number;
  logic [13:0] out_pos_x;
  logic [13:0] out_pos_y;
  logic [9:0]  out_pen_pressure;
  logic        out_last_of_run;

  pen_touch_packet_event_decoder_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_kind    (out_event_kind),
    .out_event_source  (out_event_source),
    .out_button_number (out_button_number),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_pen_pressure  (out_pen_pressure),
    .out_last_of_run   (out_last_of_run)
  );

  // predictor state
  logic [6:0]  hdr_bits = '0;
  logic [7:0]  body_mem [BodyDepth];
  byte_count_t body_cnt = '0;
  logic        framing = 1'b0;
  logic        pen_near = 1'b0;
  logic        eraser_on = 1'b0;
  logic        tip_down = 1'b0;
  logic        lower_down = 1'b0;
  logic        upper_down = 1'b0;
  logic        finger_down = 1'b0;
  logic [13:0] pkt_x;
  logic [13:0] pkt_y;
  logic [9:0]  pkt_pressure;

  tablet_event_t packet_events[$];
  tablet_event_t events_awaited[$];
  logic [7:0]    rx_bytes_pending[$];

  int bytes_sent = 0;
  int bytes_taken = 0;
  int events_checked = 0;
  int fault_count = 0;
  int pen_pkts = 0;
  int touch_pkts = 0;
  int control_pkts = 0;
  int sender_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  tablet_event_t want;
  tablet_event_t seen;

  function automatic void note_event(ev_kind_t kind, ev_src_t src, ev_btn_t btn);
    tablet_event_t e;
    e.kind = kind;
    e.src = src;
    e.btn = btn;
    e.x = pkt_x;
    e.y = pkt_y;
    e.pressure = pkt_pressure;
    e.last = 1'b0;
    packet_events.push_back(e);
  endfunction

  function automatic void decode_touch();
    ev_kind_t kind;
    pkt_x = {body_mem[0][6:0], body_mem[1][6:0]};
    pkt_y = {body_mem[2][6:0], body_mem[3][6:0]};
    pkt_pressure = '0;
    if (pen_near) return;
    if (!hdr_bits[0] && finger_down) begin
      finger_down = 1'b0;
      kind = KIND_RELEASE;
    end else if (hdr_bits[0] && !finger_down) begin
      finger_down = 1'b1;
      kind = KIND_PRESS;
    end else begin
      kind = KIND_MOVE;
    end
    note_event(kind, SRC_TOUCH, BTN_TIP);
  endfunction

  function automatic void decode_pen();
    logic [6:0] b6;
    logic       tip;
    logic       b1;
    logic       b2;
    logic       prox;
    ev_src_t    src;
    b6 = body_mem[5][6:0];
    tip = hdr_bits[0];
    b1 = hdr_bits[1];
    b2 = hdr_bits[2];
    prox = hdr_bits[5];
    pkt_x = {body_mem[0][6:0], body_mem[1][6:2], b6[6:5]};
    pkt_y = {body_mem[2][6:0], body_mem[3][6:2], b6[4:3]};
    pkt_pressure = {b6[2:0], body_mem[4][6:0]};
    if (prox && !pen_near) begin
      pen_near = 1'b1;
      eraser_on = !tip && b2;
      note_event(KIND_PROX_IN, eraser_on ? SRC_ERASER : SRC_TIP, BTN_NONE);
    end else if (!prox && pen_near) begin
      pen_near = 1'b0;
      note_event(KIND_PROX_OUT, eraser_on ? SRC_ERASER : SRC_TIP, BTN_NONE);
    end else if (eraser_on && !b2) begin
      note_event(KIND_PROX_OUT, SRC_ERASER, BTN_NONE);
      note_event(KIND_PROX_IN, SRC_TIP, BTN_NONE);
      eraser_on = 1'b0;
    end else if (!eraser_on && !tip && b2) begin
      note_event(KIND_PROX_OUT, SRC_TIP, BTN_NONE);
      note_event(KIND_PROX_IN, SRC_ERASER, BTN_NONE);
      eraser_on = 1'b1;
    end
    src = eraser_on ? SRC_ERASER : SRC_TIP;
    if (tip != tip_down) begin
      tip_down = tip;
      note_event(tip ? KIND_PRESS : KIND_RELEASE, src, BTN_TIP);
    end
    if (!eraser_on) begin
      if (b1 != lower_down) begin
        lower_down = b1;
        note_event(b1 ? KIND_PRESS : KIND_RELEASE, SRC_TIP, BTN_LOWER);
      end
      if (b2 != upper_down) begin
        upper_down = b2;
        note_event(b2 ? KIND_PRESS : KIND_RELEASE, SRC_TIP, BTN_UPPER);
      end
    end
    note_event(KIND_MOVE, src, BTN_NONE);
  endfunction

  function automatic void decode_rx_byte(logic [7:0] b);
    byte_count_t plen;
    packet_events.delete();
    if (b[7]) begin
      hdr_bits = b[6:0];
      body_cnt = 4'd1;
      framing = 1'b1;
    end else if (framing) begin
      if (body_cnt >= 4'd1 && body_cnt <= 4'd8) body_mem[3'(body_cnt - 4'd1)] = b;
      body_cnt = body_cnt + 4'd1;
      plen = hdr_bits[6] ? LEN_CONTROL : (hdr_bits[4] ? LEN_TOUCH : LEN_PEN);
      if (body_cnt >= plen) begin
        framing = 1'b0;
        body_cnt = '0;
        if (plen == LEN_TOUCH) decode_touch();
        else if (plen == LEN_PEN) decode_pen();
      end
    end
    if (packet_events.size() != 0) packet_events[packet_events.size() - 1].last = 1'b1;
    foreach (packet_events[i]) events_awaited.push_back(packet_events[i]);
  endfunction

  function automatic void report_event_fault(string what, tablet_event_t exp_ev,
                                             tablet_event_t got_ev);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%0t %s: expected kind %0d src %0d btn %0d x %0d y %0d p %0d last %0d",
               $realtime, what, exp_ev.kind, exp_ev.src, exp_ev.btn, exp_ev.x, exp_ev.y,
               exp_ev.pressure, exp_ev.last);
      $display("    got kind %0d src %0d btn %0d x %0d y %0d p %0d last %0d",
               got_ev.kind, got_ev.src, got_ev.btn, got_ev.x, got_ev.y,
               got_ev.pressure, got_ev.last);
    end
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_rx_byte <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_rx_byte(in_rx_byte);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (rx_bytes_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_rx_byte <= rx_bytes_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // event monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen = {out_event_kind, out_event_source, out_button_number, out_pos_x, out_pos_y,
              out_pen_pressure, out_last_of_run};
      if (events_awaited.size() == 0) begin
        report_event_fault("unexpected event", '0, seen);
      end else begin
        want = events_awaited.pop_front();
        if (seen !== want) report_event_fault("event mismatch", want, seen);
      end
      events_checked++;
    end
  end

  function automatic logic [7:0] body_value();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'h7f;
      default: return 8'($urandom_range(127));
    endcase
  endfunction

  task automatic queue_byte(logic [7:0] b);
    rx_bytes_pending.push_back(b);
    bytes_sent++;
  endtask

  task automatic queue_pen();
    logic [7:0] h;
    h = 8'h80;
    h[5] = ($urandom_range(99) < 70);
    h[3] = 1'($urandom);
    h[2:0] = 3'($urandom);
    queue_byte(h);
    repeat (8) queue_byte(body_value());
    pen_pkts++;
  endtask

  task automatic queue_touch();
    logic [7:0] h;
    h = 8'h90;
    h[5] = 1'($urandom);
    h[3:0] = 4'($urandom);
    queue_byte(h);
    repeat (4) queue_byte(body_value());
    touch_pkts++;
  endtask

  task automatic queue_control();
    logic [7:0] h;
    h = 8'hc0;
    h[5:0] = 6'($urandom);
    queue_byte(h);
    repeat (10) queue_byte(body_value());
    control_pkts++;
  endtask

  task automatic queue_random_traffic(int n);
    int start;
    int pick;
    start = bytes_sent;
    while (bytes_sent - start < n) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        queue_pen();
      end else if (pick < 75) begin
        queue_touch();
      end else if (pick < 82) begin
        queue_control();
      end else if (pick < 91) begin
        // truncated packet, abandoned by the next start byte
        queue_byte(8'h80 | 8'($urandom_range(127)));
        repeat ($urandom_range(3)) queue_byte(body_value());
      end else begin
        repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(127)));
      end
    end
  endtask

  task automatic wait_for_idle();
    while (bytes_taken != bytes_sent || events_awaited.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int gap_pct, int stall_pct, int n);
    sender_idle_pct = gap_pct;
    rx_stall_pct = stall_pct;
    queue_random_traffic(n);
    wait_for_idle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // stray byte while hunting, abandoned touch, touch extremes, pen entry,
    // then a touch that the nearby pen suppresses
    queue_byte(8'h00);
    queue_byte(8'h90);
    queue_byte(8'h7f);
    queue_byte(8'h91);
    repeat (4) queue_byte(8'h7f);
    queue_byte(8'h91);
    repeat (4) queue_byte(8'h00);
    queue_byte(8'ha1);
    repeat (8) queue_byte(8'h7f);
    queue_byte(8'h90);
    repeat (4) queue_byte(8'h00);
    wait_for_idle();

    run_phase(0, 0, 88);
    run_phase(50, 0, 88);
    run_phase(0, 50, 88);
    run_phase(6, 6, 88);

    // sender at full rate against a long receiver hold-off
    sender_idle_pct = 0;
    rx_stall_pct = 0;
    queue_random_traffic(90);
    hold_req++;
    wait_for_idle();

    repeat (20) @(posedge clk);
    $display("Sent %0d bytes: %0d pen, %0d touch and %0d control packets plus stray traffic.",
             bytes_sent, pen_pkts, touch_pkts, control_pkts);
    $display("Checked %0d events across gap, stall and long hold-off phases.",
             events_checked);
    if (fault_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d events outstanding.", events_awaited.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/ptpe_pkg.sv
hdl/pen_touch_packet_event_decoder_top.sv
tb/pen_touch_packet_event_decoder_top_test.sv
